/* design/nspn_pkg.sv */
// ----------------------------------------------------------------------------
// nspn_pkg
// Shared constants and cell-level functions of the nibble SPN block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package nspn_pkg;

    localparam int BLOCK_W    = 64;
    localparam int CELL_W     = 4;
    localparam int CELL_COUNT = BLOCK_W / CELL_W;
    localparam int MAIN_ROUNDS = 9;
    localparam int ROUND_COUNT = MAIN_ROUNDS + 1;
    localparam int KEY_STEP   = 5;
    localparam logic [4:0] FIELD_POLY = 5'h13;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [CELL_W-1:0]  t_cell;
    typedef t_cell t_cell_tab [CELL_COUNT];
    typedef int    t_idx_tab  [CELL_COUNT];

    localparam t_cell_tab SBOX_TAB = '{
        4'h1, 4'h3, 4'h0, 4'h2, 4'h7, 4'he, 4'h4, 4'hd,
        4'h9, 4'ha, 4'hc, 4'h6, 4'hf, 4'h5, 4'h8, 4'hb
    };

    // Rows of the column matrix, flattened row by row.
    localparam t_cell_tab MIX_MAT = '{
        4'h8, 4'h9, 4'h1, 4'h8,
        4'h3, 4'h2, 4'h9, 4'h9,
        4'h2, 4'h3, 4'h8, 4'h9,
        4'h9, 4'h9, 4'h8, 4'h1
    };

    localparam t_idx_tab PERM_TAB = '{
        0, 13, 10, 7, 4, 1, 14, 11, 8, 5, 2, 15, 12, 9, 6, 3
    };

    // Multiply in GF(2^4) modulo x^4+x+1.
    function automatic t_cell gf_mul(input t_cell a, input t_cell b);
        t_cell p;
        t_cell x;
        p = '0;
        x = a;
        for (int i = 0; i < CELL_W; i++) begin
            if (b[i]) begin
                p = p ^ x;
            end
            if (x[CELL_W-1]) begin
                x = {x[CELL_W-2:0], 1'b0} ^ FIELD_POLY[CELL_W-1:0];
            end else begin
                x = {x[CELL_W-2:0], 1'b0};
            end
        end
        return p;
    endfunction

    function automatic t_block rotl(input t_block x, input int n);
        t_block y;
        y = x;
        for (int i = 0; i < n % BLOCK_W; i++) begin
            y = {y[BLOCK_W-2:0], y[BLOCK_W-1]};
        end
        return y;
    endfunction

    // Round key r: upper key half for even r, lower for odd r.
    function automatic t_block round_key(input t_block hi, input t_block lo, input int r);
        if (r % 2 == 1) begin
            return rotl(lo, KEY_STEP * (r / 2));
        end
        return rotl(hi, KEY_STEP * (r / 2));
    endfunction

    // Bit flipped in every cell after round r.
    function automatic t_cell flip_mask(input int r);
        if (r == 1 || r == 5) begin
            return 4'h4;
        end
        if (r == 2 || r == 6) begin
            return 4'h2;
        end
        if (r == 3 || r == 7) begin
            return 4'h1;
        end
        return 4'h0;
    endfunction

endpackage

`default_nettype wire

/* design/nibble_spn_block_cipher_64_unit.sv */
// ----------------------------------------------------------------------------
// nibble_spn_block_cipher_64_unit
// Fully unrolled encryption pipeline: 64-bit block, 128-bit key per beat.
// ----------------------------------------------------------------------------
//  channel  | direction | ports                                   | handshake
//  ---------+-----------+-----------------------------------------+------------------
//  command  | in        | i_key_high, i_key_low, i_plaintext      | start & !busy
//  result   | out       | o_ciphertext                            | o_done, one cycle
//
//  A beat is taken in every cycle that start is high; busy stays low, since
//  nothing downstream can hold the pipeline.
//  The pipe holds one whitening stage (round key 0) plus ten round
//  stages (nine full rounds and the final round), each one register deep.
//  Throughput is one block per cycle; the key travels down the pipe with
//  its block, so every beat may carry a different key.
//  Synchronous active-low reset clears only the valid bits; data registers
//  hold whatever they last took.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_spn_block_cipher_64_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire nspn_pkg::t_block i_key_high,
    input  wire nspn_pkg::t_block i_key_low,
    input  wire nspn_pkg::t_block i_plaintext,
    output logic                  o_done,
    output nspn_pkg::t_block      o_ciphertext
);
    import nspn_pkg::*;

    // Stage 0 registers: whitened block plus the key it travels with.
    logic   r_valid0;
    t_block r_state0, r_key_high0, r_key_low0;

    // Links between stages; index s feeds round s.
    logic   stg_valid [ROUND_COUNT+1];
    t_block stg_state [ROUND_COUNT+1];
    t_block stg_khi   [ROUND_COUNT+1];
    t_block stg_klo   [ROUND_COUNT+1];

    // Never stall: the pipeline advances every cycle.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else begin
            r_valid0 <= start & ~busy;
        end
    end

    // Add round key 0 on entry.
    always_ff @(posedge i_clk) begin
        r_state0    <= i_plaintext ^ round_key(i_key_high, i_key_low, 0);
        r_key_high0 <= i_key_high;
        r_key_low0  <= i_key_low;
    end

    assign stg_valid[0] = r_valid0;
    assign stg_state[0] = r_state0;
    assign stg_khi[0]   = r_key_high0;
    assign stg_klo[0]   = r_key_low0;

    // The final round skips the column mix inside nspn_round; its key
    // outputs go nowhere past the last link.
    for (genvar s = 0; s < ROUND_COUNT; s++) begin : g_round
        nspn_round #(
            .ROUND_IDX (s)
        ) u_round (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (stg_valid[s]),
            .i_state    (stg_state[s]),
            .i_key_high (stg_khi[s]),
            .i_key_low  (stg_klo[s]),
            .o_valid    (stg_valid[s+1]),
            .o_state    (stg_state[s+1]),
            .o_key_high (stg_khi[s+1]),
            .o_key_low  (stg_klo[s+1])
        );
    end

    assign o_done       = stg_valid[ROUND_COUNT];
    assign o_ciphertext = stg_state[ROUND_COUNT];

endmodule

`default_nettype wire

/* design/nspn_round.sv */
// ----------------------------------------------------------------------------
// nspn_round
// One registered cipher round: s-box, column mix (skipped in the last
// round), cell permutation, bit flip and round-key addition.
// ----------------------------------------------------------------------------
`default_nettype none

module nspn_round #(
    parameter int ROUND_IDX = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire nspn_pkg::t_block i_state,
    input  wire nspn_pkg::t_block i_key_high,
    input  wire nspn_pkg::t_block i_key_low,
    output logic                  o_valid,
    output nspn_pkg::t_block      o_state,
    output nspn_pkg::t_block      o_key_high,
    output nspn_pkg::t_block      o_key_low
);
    import nspn_pkg::*;

    localparam bit    DO_MIX = (ROUND_IDX < MAIN_ROUNDS);
    localparam t_cell FLIP   = flip_mask(ROUND_IDX);

    logic   r_valid;
    t_block r_state, r_key_high, r_key_low;
    t_block n_state;
    t_block rkey;
    t_cell  sub   [CELL_COUNT];
    t_cell  mixed [CELL_COUNT];
    t_cell  acc;

    assign rkey = round_key(i_key_high, i_key_low, ROUND_IDX + 1);

    always_comb begin
        for (int c = 0; c < CELL_COUNT; c++) begin
            sub[c] = SBOX_TAB[i_state[BLOCK_W-1-CELL_W*c -: CELL_W]];
        end
        for (int col = 0; col < CELL_COUNT; col += 4) begin
            for (int j = 0; j < 4; j++) begin
                acc = '0;
                for (int k = 0; k < 4; k++) begin
                    acc = acc ^ gf_mul(MIX_MAT[4*j+k], sub[col+k]);
                end
                mixed[col+j] = DO_MIX ? acc : sub[col+j];
            end
        end
        for (int c = 0; c < CELL_COUNT; c++) begin
            n_state[BLOCK_W-1-CELL_W*c -: CELL_W] = mixed[PERM_TAB[c]] ^ FLIP
                ^ rkey[BLOCK_W-1-CELL_W*c -: CELL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state    <= n_state;
        r_key_high <= i_key_high;
        r_key_low  <= i_key_low;
    end

    assign o_valid    = r_valid;
    assign o_state    = r_state;
    assign o_key_high = r_key_high;
    assign o_key_low  = r_key_low;

endmodule

`default_nettype wire
